/* rtl/tmid_pkg.sv */
package tmid_pkg;

    // Coordinate width, Q16.16 at the default
    localparam int COORD_W = 32;
    // Point difference carries one extra bit
    localparam int DIFF_W  = COORD_W + 1;
    // Matrix entry width (cell Q16.16, inverse Q2.30)
    localparam int ENT_W   = 32;
    // Fraction kept modulo 1 with this many fraction bits
    localparam int FRAC_W  = 46;
    // Split point of the modular fraction product
    localparam int HALF_W  = FRAC_W / 2;
    // Wrapped fraction, signed Q.30 in [-0.5, 0.5]
    localparam int WRAP_W  = 31;
    // Back-mapped product and rounded displacement widths
    localparam int PROD_W  = ENT_W + WRAP_W;
    localparam int DISP_W  = 34;
    // Squared length and distance
    localparam int SQ_W    = 64;
    localparam int DIST_W  = 32;
    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELL_XX_XY = 3'd0,
        REG_CELL_XZ_YY = 3'd1,
        REG_CELL_YZ_ZZ = 3'd2,
        REG_INV_XX_XY  = 3'd3,
        REG_INV_XZ_YY  = 3'd4,
        REG_INV_YZ_ZZ  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] image_dx;
        logic signed [COORD_W-1:0] image_dy;
        logic signed [COORD_W-1:0] image_dz;
        logic        [DIST_W-1:0]  distance;
    } t_out_item;

    // Upper-triangular matrix entries
    typedef struct packed {
        logic signed [ENT_W-1:0] xx;
        logic signed [ENT_W-1:0] xy;
        logic signed [ENT_W-1:0] xz;
        logic signed [ENT_W-1:0] yy;
        logic signed [ENT_W-1:0] yz;
        logic signed [ENT_W-1:0] zz;
    } t_mat;

    // Wrapped fractional coordinates
    typedef struct packed {
        logic signed [WRAP_W-1:0] x;
        logic signed [WRAP_W-1:0] y;
        logic signed [WRAP_W-1:0] z;
    } t_wrap;

    // Saturated displacement plus squared length
    typedef struct packed {
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic signed [COORD_W-1:0] dz;
        logic        [SQ_W-1:0]    sq;
    } t_dsq;

endpackage

/* rtl/tmid_frac.sv */
// Cartesian difference to wrapped fractional coordinates, three stages
module tmid_frac import tmid_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  t_mat     i_inv,
    output logic     o_valid,
    input  logic     i_ready,
    output t_wrap    o_wrap
);

    localparam int NSTG = 3;

    typedef struct packed {
        logic [FRAC_W-1:0] lo;
        logic [HALF_W-1:0] hi;
    } t_pp;

    // Product modulo 2^FRAC_W as two partial products
    function automatic t_pp part(logic signed [ENT_W-1:0] c,
                                 logic signed [DIFF_W-1:0] d);
        logic [FRAC_W-1:0]        cf;
        logic [FRAC_W-1:0]        df;
        logic [FRAC_W+HALF_W-1:0] pl;
        logic [FRAC_W-1:0]        ph;
        t_pp                      res;
        cf = FRAC_W'(c);
        df = FRAC_W'(d);
        pl = (FRAC_W+HALF_W)'(cf) * (FRAC_W+HALF_W)'(df[HALF_W-1:0]);
        ph = FRAC_W'(cf[HALF_W-1:0]) * FRAC_W'(df[FRAC_W-1:HALF_W]);
        res.lo = pl[FRAC_W-1:0];
        res.hi = ph[HALF_W-1:0];
        return res;
    endfunction

    // Shift the modulo-1 sum into [-0.5, 0.5], rounded to Q.30
    function automatic logic signed [WRAP_W-1:0] wrap(logic [FRAC_W-1:0] raw);
        logic [FRAC_W-1:0] b;
        logic [FRAC_W:0]   t;
        logic [WRAP_W-1:0] r;
        b = raw + (FRAC_W'(1) << (FRAC_W - 1));
        t = {1'b0, b} + ((FRAC_W+1)'(1) << 15);
        r = t[FRAC_W:16];
        return signed'(r - (WRAP_W'(1) << 29));
    endfunction

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    t_pp r_pxx, r_pxy, r_pxz, r_pyy, r_pyz, r_pzz;
    t_wrap r_w;
    logic [FRAC_W-1:0] n_fx, n_fy, n_fz;

    // Bubble-collapsing stage enables
    assign en[2]   = !r_vld[2] || i_ready;
    assign en[1]   = !r_vld[1] || en[2];
    assign en[0]   = !r_vld[0] || en[1];
    assign o_ready = en[0];
    assign o_valid = r_vld[2];
    assign o_wrap  = r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
        end
    end

    // Stage 1: point difference
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dx <= DIFF_W'(i_item.first_x) - DIFF_W'(i_item.second_x);
            r_dy <= DIFF_W'(i_item.first_y) - DIFF_W'(i_item.second_y);
            r_dz <= DIFF_W'(i_item.first_z) - DIFF_W'(i_item.second_z);
        end
    end

    // Stage 2: partial products with the inverse
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_pxx <= part(i_inv.xx, r_dx);
            r_pxy <= part(i_inv.xy, r_dy);
            r_pxz <= part(i_inv.xz, r_dz);
            r_pyy <= part(i_inv.yy, r_dy);
            r_pyz <= part(i_inv.yz, r_dz);
            r_pzz <= part(i_inv.zz, r_dz);
        end
    end

    // Stage 3: modular sums and wrap
    always_comb begin
        n_fx = r_pxx.lo + {r_pxx.hi, HALF_W'(0)} + r_pxy.lo + {r_pxy.hi, HALF_W'(0)}
             + r_pxz.lo + {r_pxz.hi, HALF_W'(0)};
        n_fy = r_pyy.lo + {r_pyy.hi, HALF_W'(0)} + r_pyz.lo + {r_pyz.hi, HALF_W'(0)};
        n_fz = r_pzz.lo + {r_pzz.hi, HALF_W'(0)};
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_w.x <= wrap(n_fx);
            r_w.y <= wrap(n_fy);
            r_w.z <= wrap(n_fz);
        end
    end

endmodule

/* rtl/tmid_cart.sv */
// Wrapped fraction back to Cartesian, saturation and squared length, five stages
module tmid_cart import tmid_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_wrap i_wrap,
    input  t_mat  i_cell,
    output logic  o_valid,
    input  logic  i_ready,
    output t_dsq  o_item
);

    localparam int NSTG = 5;
    localparam logic signed [63:0] COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
    localparam logic signed [63:0] COORD_MIN = -COORD_MAX - 64'sd1;

    function automatic logic signed [DISP_W-1:0] round_q16(logic signed [PROD_W-1:0] a,
                                                           logic signed [PROD_W-1:0] b,
                                                           logic signed [PROD_W-1:0] c);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b) + 64'(c) + (64'sd1 <<< 29);
        return s[63:30];
    endfunction

    function automatic logic [SQ_W-1:0] clamp_sq(logic signed [DISP_W-1:0] e);
        logic [DISP_W-1:0] a;
        logic [DIST_W-1:0] c;
        a = e[DISP_W-1] ? DISP_W'(-e) : DISP_W'(e);
        c = (a > DISP_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : a[DIST_W-1:0];
        return SQ_W'(c) * SQ_W'(c);
    endfunction

    function automatic logic signed [COORD_W-1:0] sat(logic signed [DISP_W-1:0] e);
        logic signed [63:0] v;
        v = 64'(e);
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [SQ_W-1:0] sat_add(logic [SQ_W-1:0] a, logic [SQ_W-1:0] b);
        logic [SQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
    endfunction

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    logic signed [PROD_W-1:0] r_pxx, r_pxy, r_pxz, r_pyy, r_pyz, r_pzz;
    logic signed [DISP_W-1:0] r_ex, r_ey, r_ez;
    logic [SQ_W-1:0]          r_qx, r_qy, r_qz, r_qxy, r_qz2;
    logic signed [COORD_W-1:0] r_sx, r_sy, r_sz, r_tx, r_ty, r_tz;
    t_dsq                     r_out;

    // Bubble-collapsing stage enables
    assign en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
    for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
        assign en[k] = !r_vld[k] || en[k+1];
    end
    assign o_ready = en[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 1: cell times wrapped fraction
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_pxx <= PROD_W'(i_cell.xx) * PROD_W'(i_wrap.x);
            r_pxy <= PROD_W'(i_cell.xy) * PROD_W'(i_wrap.y);
            r_pxz <= PROD_W'(i_cell.xz) * PROD_W'(i_wrap.z);
            r_pyy <= PROD_W'(i_cell.yy) * PROD_W'(i_wrap.y);
            r_pyz <= PROD_W'(i_cell.yz) * PROD_W'(i_wrap.z);
            r_pzz <= PROD_W'(i_cell.zz) * PROD_W'(i_wrap.z);
        end
    end

    // Stage 2: row sums rounded half up to Q16.16
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_ex <= round_q16(r_pxx, r_pxy, r_pxz);
            r_ey <= round_q16(r_pyy, r_pyz, PROD_W'(0));
            r_ez <= round_q16(r_pzz, PROD_W'(0), PROD_W'(0));
        end
    end

    // Stage 3: clamped squares and saturated components
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_qx <= clamp_sq(r_ex);
            r_qy <= clamp_sq(r_ey);
            r_qz <= clamp_sq(r_ez);
            r_sx <= sat(r_ex);
            r_sy <= sat(r_ey);
            r_sz <= sat(r_ez);
        end
    end

    // Stage 4: first saturating add
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_qxy <= sat_add(r_qx, r_qy);
            r_qz2 <= r_qz;
            r_tx  <= r_sx;
            r_ty  <= r_sy;
            r_tz  <= r_sz;
        end
    end

    // Stage 5: second saturating add
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_out.sq <= sat_add(r_qxy, r_qz2);
            r_out.dx <= r_tx;
            r_out.dy <= r_ty;
            r_out.dz <= r_tz;
        end
    end

endmodule

/* rtl/tmid_sqrt.sv */
// Pipelined integer square root, four result bits per stage
module tmid_sqrt import tmid_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_dsq      i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int STEPS = 4;
    localparam int NSTG  = DIST_W / STEPS;
    localparam int REM_W = DIST_W + 2;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DIST_W-1:0] root;
        logic [SQ_W-1:0]   v;
    } t_sq_st;

    // STEPS digit-by-digit iterations, two radicand bits each
    function automatic t_sq_st iter(t_sq_st s);
        t_sq_st            n;
        logic [REM_W+1:0]  tmp;
        logic [REM_W+1:0]  trial;
        n = s;
        for (int k = 0; k < STEPS; k++) begin
            tmp   = {n.rem, n.v[SQ_W-1:SQ_W-2]};
            trial = (REM_W+2)'({n.root, 2'b01});
            if (tmp >= trial) begin
                tmp    = tmp - trial;
                n.root = {n.root[DIST_W-2:0], 1'b1};
            end else begin
                n.root = {n.root[DIST_W-2:0], 1'b0};
            end
            n.rem = tmp[REM_W-1:0];
            n.v   = {n.v[SQ_W-3:0], 2'b00};
        end
        return n;
    endfunction

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    t_sq_st r_st [NSTG];
    logic signed [COORD_W-1:0] r_dx [NSTG];
    logic signed [COORD_W-1:0] r_dy [NSTG];
    logic signed [COORD_W-1:0] r_dz [NSTG];
    t_sq_st n_first;

    // Bubble-collapsing stage enables
    assign en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
    for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
        assign en[k] = !r_vld[k] || en[k+1];
    end
    assign o_ready = en[0];
    assign o_valid = r_vld[NSTG-1];

    assign o_item.image_dx = r_dx[NSTG-1];
    assign o_item.image_dy = r_dy[NSTG-1];
    assign o_item.image_dz = r_dz[NSTG-1];
    assign o_item.distance = r_st[NSTG-1].root;

    always_comb begin
        n_first.rem  = '0;
        n_first.root = '0;
        n_first.v    = i_item.sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Root stages, displacement carried alongside
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_st[0] <= iter(n_first);
            r_dx[0] <= i_item.dx;
            r_dy[0] <= i_item.dy;
            r_dz[0] <= i_item.dz;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                r_st[k] <= iter(r_st[k-1]);
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
                r_dz[k] <= r_dz[k-1];
            end
        end
    end

`ifndef SYNTH
    // Finished root leaves a remainder no larger than twice the root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] |-> (r_st[NSTG-1].rem <= REM_W'({r_st[NSTG-1].root, 1'b0})))
        else $error("square root remainder out of bound");
    // A held result stays in the last stage
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] && !i_ready |=> r_vld[NSTG-1])
        else $error("stalled result lost");
    // The input side only backs off when the first and last stages are occupied
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_vld[0] && r_vld[NSTG-1])
        else $error("back-pressure without a full pipeline");
`endif

endmodule

/* rtl/triclinic_min_image_distance.sv */
// Minimum-image displacement and distance between two points in a periodic
// triclinic cell. One point pair is taken per clock while o_in_ready is set:
// 3 stages map the difference into fractional space and wrap it, 5 stages
// map it back, saturate and form the squared length, and 8 stages of the
// square root unit produce the distance four bits at a time. Back-pressure
// collapses bubbles stage by stage, so a waiting result does not stop new
// pairs entering empty stages. The cell matrix (Q16.16) and its inverse
// (Q2.30) are written through the configuration channel, which is always
// ready; write them only while the block holds no pairs. Reset loads the
// identity into both.
module triclinic_min_image_distance import tmid_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic signed [ENT_W-1:0] CELL_ONE = ENT_W'(32'h0001_0000);
    localparam logic signed [ENT_W-1:0] INV_ONE  = ENT_W'(32'h4000_0000);
    // Identity matrices in entry order xx, xy, xz, yy, yz, zz
    localparam t_mat CELL_RST = {CELL_ONE, ENT_W'(0), ENT_W'(0),
                                 CELL_ONE, ENT_W'(0), CELL_ONE};
    localparam t_mat INV_RST  = {INV_ONE, ENT_W'(0), ENT_W'(0),
                                 INV_ONE, ENT_W'(0), INV_ONE};

    t_mat  r_cell;
    t_mat  r_inv;
    logic  frac_vld, frac_rdy, cart_vld, cart_rdy;
    t_wrap frac_w;
    t_dsq  cart_q;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= CELL_RST;
            r_inv  <= INV_RST;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_CELL_XX_XY: {r_cell.xx, r_cell.xy} <= i_cfg_data;
                REG_CELL_XZ_YY: {r_cell.xz, r_cell.yy} <= i_cfg_data;
                REG_CELL_YZ_ZZ: {r_cell.yz, r_cell.zz} <= i_cfg_data;
                REG_INV_XX_XY:  {r_inv.xx, r_inv.xy}   <= i_cfg_data;
                REG_INV_XZ_YY:  {r_inv.xz, r_inv.yy}   <= i_cfg_data;
                REG_INV_YZ_ZZ:  {r_inv.yz, r_inv.zz}   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tmid_frac u_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in),
        .i_inv   (r_inv),
        .o_valid (frac_vld),
        .i_ready (frac_rdy),
        .o_wrap  (frac_w)
    );

    tmid_cart u_cart (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (frac_vld),
        .o_ready (frac_rdy),
        .i_wrap  (frac_w),
        .i_cell  (r_cell),
        .o_valid (cart_vld),
        .i_ready (cart_rdy),
        .o_item  (cart_q)
    );

    tmid_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cart_vld),
        .o_ready (cart_rdy),
        .i_item  (cart_q),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out)
    );

endmodule
